// File: hw/rtl/rtp_receiver_statistics_top_assert.svh
// Assertion macros used by the checker file of the RTP statistics block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RTP_RECEIVER_STATISTICS_TOP_ASSERT_SVH
`define RTP_RECEIVER_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTPSTAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTPSTAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rtpstat_pkg.sv
// ----------------------------------------------------------------------------
// RTP receiver statistics package
// Shared types and constants of the receive statistics block.
// ----------------------------------------------------------------------------
package rtpstat_pkg;

    localparam logic [1:0] OP_PKT  = 2'd0;
    localparam logic [1:0] OP_REC  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] CFG_IDX_SSRC  = 2'd0;
    localparam logic [1:0] CFG_IDX_LIMIT = 2'd1;

    localparam logic [15:0] LIMIT_RESET = 16'd32768;
    localparam logic [19:0] US_PER_S    = 20'd1000000;
    localparam logic [31:0] PERIOD_NUM  = 32'd1480000000;
    localparam logic [63:0] PERIOD_MIN  = 64'd10000;
    localparam logic [63:0] PERIOD_MAX  = 64'd10000000;
    localparam logic [31:0] BW_REPORT_MIN = 32'd14;

    localparam logic signed [25:0] LOST_MAX = 26'sd8388607;
    localparam logic signed [25:0] LOST_MIN = -26'sd8388608;

    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        K_PKT,
        K_REC,
        K_TICK
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] seq_num;
        logic [31:0] source_id;
        logic [15:0] payload_bytes;
        logic [15:0] packet_bytes;
        logic [31:0] elapsed_us;
    } qitem_t;

    typedef struct packed {
        logic   valid;
        qitem_t item;
    } qhead_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_wr_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_DSTART,
        B_DWAIT,
        B_FRAC,
        B_FWAIT,
        B_CLR,
        B_PWAIT,
        B_EMIT
    } bstate_t;

endpackage

// File: hw/rtl/rtpstat_if.sv
// ----------------------------------------------------------------------------
// RTP statistics channel interfaces
// Valid/ready channels for incoming items and outgoing receiver reports.
// ----------------------------------------------------------------------------
interface rtpstat_pkt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] seq_num;
    logic [31:0] source_id;
    logic [15:0] payload_bytes;
    logic [15:0] packet_bytes;
    logic [31:0] elapsed_us;

    modport source (output valid, opcode, seq_num, source_id, payload_bytes,
                    packet_bytes, elapsed_us, input ready);
    modport sink (input valid, opcode, seq_num, source_id, payload_bytes,
                  packet_bytes, elapsed_us, output ready);
    modport mon (input valid, ready, opcode, seq_num, source_id, payload_bytes,
                 packet_bytes, elapsed_us);
endinterface

interface rtpstat_rpt_if;
    logic               valid;
    logic               ready;
    logic [31:0]        reporter_ssrc;
    logic [31:0]        reported_ssrc;
    logic [7:0]         fraction_lost;
    logic signed [23:0] cumulative_lost;
    logic [31:0]        ext_highest_seq;
    logic [31:0]        bw_payload;
    logic [31:0]        bw_total;
    logic [31:0]        bw_recovered;
    logic [23:0]        next_period_us;

    modport source (output valid, reporter_ssrc, reported_ssrc, fraction_lost,
                    cumulative_lost, ext_highest_seq, bw_payload, bw_total,
                    bw_recovered, next_period_us, input ready);
    modport sink (input valid, reporter_ssrc, reported_ssrc, fraction_lost,
                  cumulative_lost, ext_highest_seq, bw_payload, bw_total,
                  bw_recovered, next_period_us, output ready);
    modport mon (input valid, ready, reporter_ssrc, reported_ssrc, fraction_lost,
                 cumulative_lost, ext_highest_seq, bw_payload, bw_total,
                 bw_recovered, next_period_us);
endinterface

// File: hw/rtl/rtpstat_front.sv
// ----------------------------------------------------------------------------
// RTP statistics front end
// Accepts items, decodes the opcode and queues useful items for the back end.
// ----------------------------------------------------------------------------
module rtpstat_front
    import rtpstat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rtpstat_pkt_if.sink pkt,
    input  logic       pop,
    output qhead_t     head
);

    localparam int PW = $clog2(QDEPTH);

    qitem_t             mem [QDEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PW:0]        count_reg, count_next;
    logic               useful;
    logic               push;
    qitem_t             item;

    assign pkt.ready = (count_reg != (PW+1)'(QDEPTH));

    // Unused opcodes and zero-length ticks have no effect, so they are dropped here.
    always_comb
    begin
        useful    = 1'b0;
        item.kind = K_PKT;
        case (pkt.opcode)
            OP_PKT:
            begin
                useful    = 1'b1;
                item.kind = K_PKT;
            end
            OP_REC:
            begin
                useful    = 1'b1;
                item.kind = K_REC;
            end
            OP_TICK:
            begin
                useful    = (pkt.elapsed_us != 32'd0);
                item.kind = K_TICK;
            end
            default:
            begin
                useful    = 1'b0;
                item.kind = K_PKT;
            end
        endcase
        item.seq_num       = pkt.seq_num;
        item.source_id     = pkt.source_id;
        item.payload_bytes = pkt.payload_bytes;
        item.packet_bytes  = pkt.packet_bytes;
        item.elapsed_us    = pkt.elapsed_us;
    end

    assign push = pkt.valid && pkt.ready && useful;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

endmodule

// File: hw/rtl/rtpstat_div.sv
// ----------------------------------------------------------------------------
// RTP statistics divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtpstat_div
    import rtpstat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [63:0] quo_reg;
    logic [32:0] dvs_reg;
    logic [33:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[63]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 33'(shifted - {1'b0, dvs_reg}) : shifted[32:0];
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/rtpstat_back.sv
// ----------------------------------------------------------------------------
// RTP statistics back end
// Holds the flow state, executes queued items and builds receiver reports.
// ----------------------------------------------------------------------------
module rtpstat_back
    import rtpstat_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_wr_t       cfg,
    input  qhead_t        head,
    output logic          pop,
    rtpstat_rpt_if.source rpt
);

    bstate_t            state_reg, state_next;
    logic [31:0]        sender_ssrc_reg;
    logic [15:0]        limit_reg;
    logic               started_reg, started_next;
    logic [15:0]        last_seq_reg, last_seq_next;
    logic [15:0]        wrap_reg, wrap_next;
    logic [31:0]        flow_ssrc_reg, flow_ssrc_next;
    logic signed [23:0] lost_total_reg, lost_total_next;
    logic [31:0]        lost_int_reg, lost_int_next;
    logic [31:0]        rcv_int_reg, rcv_int_next;
    logic [31:0]        rcv_total_reg, rcv_total_next;
    logic [31:0]        dup_reg, dup_next;
    logic [31:0]        misorder_reg, misorder_next;
    logic [31:0]        recov_cnt_reg, recov_cnt_next;
    logic [31:0]        pay_acc_reg, pay_acc_next;
    logic [31:0]        tot_acc_reg, tot_acc_next;
    logic [31:0]        rec_acc_reg, rec_acc_next;
    logic [31:0]        avg_pay_reg, avg_pay_next;
    logic [31:0]        avg_tot_reg, avg_tot_next;
    logic [31:0]        avg_rec_reg, avg_rec_next;
    logic [1:0]         sel_reg, sel_next;
    logic [31:0]        us_reg, us_next;
    logic [51:0]        prod_reg, prod_next;
    logic [7:0]         frac_reg, frac_next;
    logic [23:0]        period_reg, period_next;
    logic               out_valid_reg, out_valid_next;
    logic               load_out;

    logic               div_start;
    logic [63:0]        div_dividend;
    logic [32:0]        div_divisor;
    logic               div_done;
    logic [63:0]        div_q;

    logic [15:0]        seq_dist;
    logic               forward;
    logic signed [25:0] lost_delta;
    logic signed [25:0] lost_sum;
    logic [31:0]        acc_sel;
    logic [64:0]        avg_sum;
    logic [31:0]        avg_new;
    logic [39:0]        lost_x255;

    rtpstat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign seq_dist  = head.item.seq_num - last_seq_reg;
    assign forward   = (seq_dist <= limit_reg) || (seq_dist == 16'd1);
    assign lost_sum  = 26'(lost_total_reg) + lost_delta;
    assign lost_x255 = {lost_int_reg, 8'd0} - {8'd0, lost_int_reg};

    always_comb
    begin
        case (sel_reg)
            2'd0:    acc_sel = pay_acc_reg;
            2'd1:    acc_sel = tot_acc_reg;
            default: acc_sel = rec_acc_reg;
        endcase
    end

    always_comb
    begin
        case (sel_reg)
            2'd0:    avg_sum = {33'd0, avg_pay_reg} + {1'b0, div_q};
            2'd1:    avg_sum = {33'd0, avg_tot_reg} + {1'b0, div_q};
            default: avg_sum = {33'd0, avg_rec_reg} + {1'b0, div_q};
        endcase
        avg_new = (avg_sum[64:33] != 32'd0) ? 32'hFFFF_FFFF : avg_sum[32:1];
    end

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        last_seq_next   = last_seq_reg;
        wrap_next       = wrap_reg;
        flow_ssrc_next  = flow_ssrc_reg;
        lost_total_next = lost_total_reg;
        lost_int_next   = lost_int_reg;
        rcv_int_next    = rcv_int_reg;
        rcv_total_next  = rcv_total_reg;
        dup_next        = dup_reg;
        misorder_next   = misorder_reg;
        recov_cnt_next  = recov_cnt_reg;
        pay_acc_next    = pay_acc_reg;
        tot_acc_next    = tot_acc_reg;
        rec_acc_next    = rec_acc_reg;
        avg_pay_next    = avg_pay_reg;
        avg_tot_next    = avg_tot_reg;
        avg_rec_next    = avg_rec_reg;
        sel_next        = sel_reg;
        us_next         = us_reg;
        prod_next       = prod_reg;
        frac_next       = frac_reg;
        period_next     = period_reg;
        out_valid_next  = out_valid_reg && !rpt.ready;
        load_out        = 1'b0;
        pop             = 1'b0;
        div_start       = 1'b0;
        div_dividend    = {12'd0, prod_reg};
        div_divisor     = {1'b0, us_reg};
        lost_delta      = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.item.kind)
                        K_PKT:
                        begin
                            pay_acc_next = pay_acc_reg + 32'(head.item.payload_bytes);
                            tot_acc_next = tot_acc_reg + 32'(head.item.packet_bytes);
                            if (!started_reg)
                            begin
                                started_next   = 1'b1;
                                flow_ssrc_next = head.item.source_id;
                                last_seq_next  = head.item.seq_num;
                                rcv_total_next = rcv_total_reg + 1'b1;
                                rcv_int_next   = rcv_int_reg + 1'b1;
                            end
                            else if (seq_dist == 16'd0)
                            begin
                                dup_next = dup_reg + 1'b1;
                            end
                            else if (forward)
                            begin
                                // A gap of one less than the distance is counted as lost.
                                lost_delta      = 26'(seq_dist) - 26'sd1;
                                lost_int_next   = lost_int_reg + 32'(seq_dist) - 32'd1;
                                lost_total_next = (lost_sum > LOST_MAX) ? 24'(LOST_MAX)
                                                                        : lost_sum[23:0];
                                rcv_total_next  = rcv_total_reg + 1'b1;
                                rcv_int_next    = rcv_int_reg + 1'b1;
                                if (head.item.seq_num < last_seq_reg)
                                begin
                                    wrap_next = wrap_reg + 1'b1;
                                end
                                last_seq_next = head.item.seq_num;
                            end
                            else
                            begin
                                lost_delta      = -26'sd1;
                                misorder_next   = misorder_reg + 1'b1;
                                lost_total_next = (lost_sum < LOST_MIN) ? 24'(LOST_MIN)
                                                                        : lost_sum[23:0];
                                if (lost_int_reg != 32'd0)
                                begin
                                    lost_int_next = lost_int_reg - 1'b1;
                                end
                            end
                        end
                        K_REC:
                        begin
                            if (started_reg)
                            begin
                                lost_delta      = -26'sd1;
                                lost_total_next = (lost_sum < LOST_MIN) ? 24'(LOST_MIN)
                                                                        : lost_sum[23:0];
                                recov_cnt_next  = recov_cnt_reg + 1'b1;
                                rec_acc_next    = rec_acc_reg
                                                + 32'(head.item.payload_bytes);
                            end
                        end
                        default:
                        begin
                            us_next    = head.item.elapsed_us;
                            sel_next   = 2'd0;
                            state_next = B_MUL;
                        end
                    endcase
                end
            end
            B_MUL:
            begin
                prod_next  = 52'(acc_sel) * 52'(US_PER_S);
                state_next = B_DSTART;
            end
            B_DSTART:
            begin
                div_start  = 1'b1;
                state_next = B_DWAIT;
            end
            B_DWAIT:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        2'd0:    avg_pay_next = avg_new;
                        2'd1:    avg_tot_next = avg_new;
                        default: avg_rec_next = avg_new;
                    endcase
                    sel_next   = sel_reg + 1'b1;
                    state_next = (sel_reg == 2'd2) ? B_FRAC : B_MUL;
                end
            end
            B_FRAC:
            begin
                frac_next    = 8'd0;
                div_dividend = {24'd0, lost_x255};
                div_divisor  = {1'b0, lost_int_reg} + {1'b0, rcv_int_reg};
                if (lost_int_reg != 32'd0)
                begin
                    div_start  = 1'b1;
                    state_next = B_FWAIT;
                end
                else
                begin
                    state_next = B_CLR;
                end
            end
            B_FWAIT:
            begin
                if (div_done)
                begin
                    frac_next  = div_q[7:0];
                    state_next = B_CLR;
                end
            end
            B_CLR:
            begin
                pay_acc_next  = '0;
                tot_acc_next  = '0;
                rec_acc_next  = '0;
                lost_int_next = '0;
                rcv_int_next  = '0;
                div_dividend  = {32'd0, PERIOD_NUM};
                div_divisor   = {1'b0, avg_pay_reg};
                if (avg_pay_reg <= BW_REPORT_MIN)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = B_PWAIT;
                end
            end
            B_PWAIT:
            begin
                if (div_done)
                begin
                    if (div_q < PERIOD_MIN)
                    begin
                        period_next = 24'(PERIOD_MIN);
                    end
                    else if (div_q > PERIOD_MAX)
                    begin
                        period_next = 24'(PERIOD_MAX);
                    end
                    else
                    begin
                        period_next = div_q[23:0];
                    end
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (!out_valid_reg || rpt.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            sender_ssrc_reg <= '0;
            limit_reg       <= LIMIT_RESET;
            started_reg     <= 1'b0;
            last_seq_reg    <= '0;
            wrap_reg        <= '0;
            flow_ssrc_reg   <= '0;
            lost_total_reg  <= '0;
            lost_int_reg    <= '0;
            rcv_int_reg     <= '0;
            rcv_total_reg   <= '0;
            dup_reg         <= '0;
            misorder_reg    <= '0;
            recov_cnt_reg   <= '0;
            pay_acc_reg     <= '0;
            tot_acc_reg     <= '0;
            rec_acc_reg     <= '0;
            avg_pay_reg     <= '0;
            avg_tot_reg     <= '0;
            avg_rec_reg     <= '0;
            sel_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            started_reg     <= started_next;
            last_seq_reg    <= last_seq_next;
            wrap_reg        <= wrap_next;
            flow_ssrc_reg   <= flow_ssrc_next;
            lost_total_reg  <= lost_total_next;
            lost_int_reg    <= lost_int_next;
            rcv_int_reg     <= rcv_int_next;
            rcv_total_reg   <= rcv_total_next;
            dup_reg         <= dup_next;
            misorder_reg    <= misorder_next;
            recov_cnt_reg   <= recov_cnt_next;
            pay_acc_reg     <= pay_acc_next;
            tot_acc_reg     <= tot_acc_next;
            rec_acc_reg     <= rec_acc_next;
            avg_pay_reg     <= avg_pay_next;
            avg_tot_reg     <= avg_tot_next;
            avg_rec_reg     <= avg_rec_next;
            sel_reg         <= sel_next;
            out_valid_reg   <= out_valid_next;
            if (cfg.we && (cfg.index == CFG_IDX_SSRC))
            begin
                sender_ssrc_reg <= cfg.data;
            end
            if (cfg.we && (cfg.index == CFG_IDX_LIMIT))
            begin
                limit_reg <= cfg.data[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        us_reg     <= us_next;
        prod_reg   <= prod_next;
        frac_reg   <= frac_next;
        period_reg <= period_next;
        if (load_out)
        begin
            rpt.reporter_ssrc   <= sender_ssrc_reg;
            rpt.reported_ssrc   <= flow_ssrc_reg;
            rpt.fraction_lost   <= frac_reg;
            rpt.cumulative_lost <= lost_total_reg;
            rpt.ext_highest_seq <= {wrap_reg, last_seq_reg};
            rpt.bw_payload      <= avg_pay_reg;
            rpt.bw_total        <= avg_tot_reg;
            rpt.bw_recovered    <= avg_rec_reg;
            rpt.next_period_us  <= period_reg;
        end
    end

    assign rpt.valid = out_valid_reg;

endmodule

// File: hw/rtl/rtp_receiver_statistics_top.sv
// ----------------------------------------------------------------------------
// RTP receiver statistics
// Receive statistics for one RTP flow, producing receiver report fields.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the pkt channel (valid/ready): received packets, recovered
// packets and report ticks. Reports leave on the rpt channel from an output
// register. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle, which the block
// does not enforce; index 0 is the own SSRC, index 1 the misorder limit.
// A two-entry queue separates intake from execution. A packet or recovered
// item is executed in the idle state of the back end, so packets stream
// at one per cycle while no tick is in progress. A tick runs three to five
// divisions on a shared bit-serial divider plus a multiply per bandwidth;
// a reporting tick then loads its report into the output register.
// Reset clears all statistics, empties the queue and sets the misorder
// limit to 32768. When the report receiver stalls, the report holds in the
// output register; a following tick waits for it to be taken while packets
// queue up and then stall the pkt channel.
// ----------------------------------------------------------------------------
module rtp_receiver_statistics_top
    import rtpstat_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    rtpstat_pkt_if.sink   pkt,
    rtpstat_rpt_if.source rpt
);

    qhead_t  head;
    logic    pop;
    cfg_wr_t cfg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    rtpstat_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .pop   (pop),
        .head  (head)
    );

    rtpstat_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .head  (head),
        .pop   (pop),
        .rpt   (rpt)
    );

endmodule

// File: hw/rtl/rtpstat_check.sv
// ----------------------------------------------------------------------------
// RTP statistics port checker
// Watches the report channel of the top level over time.
// ----------------------------------------------------------------------------
`include "rtp_receiver_statistics_top_assert.svh"

module rtpstat_check
    import rtpstat_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rpt_valid,
    input logic        rpt_ready,
    input logic [23:0] rpt_period,
    input logic [31:0] rpt_bw_payload
);

    `RTPSTAT_ASSERT_NEXT(a_rpt_hold, rpt_valid && !rpt_ready, rpt_valid && $stable(rpt_period), "report changed while stalled")
    `RTPSTAT_ASSERT_NOW(a_period_range, rpt_valid, (rpt_period >= 24'd10000) && (rpt_period <= 24'd10000000), "period out of range")
    `RTPSTAT_ASSERT_NOW(a_bw_min, rpt_valid, rpt_bw_payload > 32'd14, "report at too low a bandwidth")

endmodule

bind rtp_receiver_statistics_top rtpstat_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .rpt_valid      (rpt.valid),
    .rpt_ready      (rpt.ready),
    .rpt_period     (rpt.next_period_us),
    .rpt_bw_payload (rpt.bw_payload)
);
